// ===== design/stc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stc_pkg;

  // Fixed field widths of the stream and configuration beats.
  localparam int unsigned PIXEL_W = 8;
  localparam int unsigned SCORE_W = 23;
  localparam int unsigned CFG_W   = 3;

  // Default upper bound of the half window and the reset value of the register.
  localparam int unsigned DEF_MAX_HALF_WINDOW = 7;
  localparam logic [CFG_W-1:0] HALF_WINDOW_RESET = 3'd3;

  // Largest squared central difference of two pixels.
  localparam int unsigned MAX_GRAD_SQ = 65025;

endpackage

`default_nettype wire

// ===== design/stc_line_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stc_line_mem #(
  parameter int unsigned AW = 6,
  parameter int unsigned DW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_a_i,
  input  wire logic [AW-1:0] raddr_b_i,
  output logic      [DW-1:0] rdata_a_o,
  output logic      [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem [2**AW];

  // Two registered read ports and one write port; a read of the entry being
  // written returns the old contents.
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/stc_score.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stc_score #(
  parameter int unsigned SUM_W = 24,
  parameter int unsigned NW    = 12
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic        [SUM_W-1:0]          sxx_i,
  input  wire logic        [SUM_W-1:0]          syy_i,
  input  wire logic signed [SUM_W:0]            sxy_i,
  input  wire logic        [NW-1:0]             div_i,
  output logic                                  res_valid_o,
  input  wire logic                             res_ready_i,
  output logic             [stc_pkg::SCORE_W-1:0] score_o
);
  import stc_pkg::*;

  localparam int unsigned QW  = SUM_W + 9;
  localparam int unsigned XW  = 2 * QW;
  localparam int unsigned RW  = QW + 3;
  localparam int unsigned CNW = $clog2(QW);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ADD, S_ROOT, S_NUM, S_DIV, S_DONE
  } state_e;

  state_e           state_q;
  logic [SUM_W-1:0] diff_q, axy_q;
  logic [SUM_W:0]   t_q;
  logic [NW-1:0]    dv_q;
  logic [2*SUM_W-1:0] sq1_q, sq2_q;
  logic [XW-1:0]    x_q;
  logic [RW-1:0]    rem_q;
  logic [QW-1:0]    root_q;
  logic [QW-1:0]    q_q;
  logic [NW-1:0]    drem_q;
  logic [CNW-1:0]   cnt_q;

  logic [SUM_W-1:0]   diff_d, axy_d;
  logic [SUM_W:0]     neg_xy;
  logic [2*SUM_W+1:0] d_sum;
  logic [RW-1:0]      rem_sh, trial;
  logic [QW-1:0]      tt, num;
  logic [NW:0]        dsh;

  // Operand preparation, one root digit and one quotient bit.
  always_comb begin
    diff_d = (sxx_i >= syy_i) ? (sxx_i - syy_i) : (syy_i - sxx_i);
    neg_xy = -sxy_i;
    axy_d  = sxy_i[SUM_W] ? neg_xy[SUM_W-1:0] : sxy_i[SUM_W-1:0];
    d_sum  = {2'b00, sq1_q} + {sq2_q, 2'b00};
    rem_sh = {rem_q[RW-3:0], x_q[XW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    tt     = {t_q, 8'h00};
    num    = (tt > root_q) ? (tt - root_q) : '0;
    dsh    = {drem_q, q_q[QW-1]};
  end

  // Sequencer: squares, sum, square root digit by digit, then division.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            diff_q  <= diff_d;
            axy_q   <= axy_d;
            t_q     <= {1'b0, sxx_i} + {1'b0, syy_i};
            dv_q    <= div_i;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          sq1_q   <= diff_q * diff_q;
          sq2_q   <= axy_q * axy_q;
          state_q <= S_ADD;
        end
        S_ADD: begin
          x_q     <= {d_sum, 16'h0000};
          rem_q   <= '0;
          root_q  <= '0;
          cnt_q   <= CNW'(QW - 1);
          state_q <= S_ROOT;
        end
        S_ROOT: begin
          x_q <= {x_q[XW-3:0], 2'b00};
          if (rem_sh >= trial) begin
            rem_q  <= rem_sh - trial;
            root_q <= {root_q[QW-2:0], 1'b1};
          end else begin
            rem_q  <= rem_sh;
            root_q <= {root_q[QW-2:0], 1'b0};
          end
          if (cnt_q == '0) begin
            state_q <= S_NUM;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_NUM: begin
          q_q     <= num;
          drem_q  <= '0;
          cnt_q   <= CNW'(QW - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (dsh >= {1'b0, dv_q}) begin
            drem_q <= NW'(dsh - {1'b0, dv_q});
            q_q    <= {q_q[QW-2:0], 1'b1};
          end else begin
            drem_q <= dsh[NW-1:0];
            q_q    <= {q_q[QW-2:0], 1'b0};
          end
          if (cnt_q == '0) begin
            state_q <= S_DONE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = (state_q == S_DONE);
  assign score_o     = q_q[SCORE_W-1:0];

endmodule

`default_nettype wire

// ===== design/shi_tomasi_corner_score.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shi-Tomasi corner score over a streamed square patch of 2h+3 pixels a side.
// Pixels enter in raster order on the slave stream; tuser set marks the
// top-left pixel of a new patch. The master stream gives one score beat, the
// smaller eigenvalue in unsigned Q8, after the last pixel of each patch.
// The configuration channel writes the half window h, which also restarts
// the patch; it is always ready.
// Pixels are taken one per cycle while a patch streams in; the line buffer
// memory is read as a pixel is taken and the sums update in the next cycle.
// After the last pixel the slave side is held off while the score unit steps
// through operand capture, squares, sum, SUM_W+9 square root digits, the
// numerator and SUM_W+9 quotient bits, until the score moves to the output
// register. A score waiting on a stalled receiver does not hold off the
// next patch; a second finished patch waits in the score unit.
// Reset sets h to 3 and clears the position, the sums and both streams.

module shi_tomasi_corner_score #(
  parameter int unsigned MAX_HALF_WINDOW = stc_pkg::DEF_MAX_HALF_WINDOW
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,  // pixel [7:0]
  input  wire logic                        s_axis_tuser,  // first_of_patch [0]
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [23:0]                      m_axis_tdata,  // score_q8 [22:0]
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [stc_pkg::CFG_W-1:0]   cfg_data_i
);
  import stc_pkg::*;

  localparam int unsigned SIDE_MAX = 2 * MAX_HALF_WINDOW + 3;
  localparam int unsigned CW       = $clog2(SIDE_MAX);
  localparam int unsigned HW       = $clog2(MAX_HALF_WINDOW + 1);
  localparam int unsigned WW       = $clog2(2 * MAX_HALF_WINDOW + 2);
  localparam int unsigned NW       = 2 * WW + 2;
  localparam int unsigned NMAX     = (2 * MAX_HALF_WINDOW + 1) * (2 * MAX_HALF_WINDOW + 1);
  localparam int unsigned SUM_W    = $clog2(NMAX * MAX_GRAD_SQ + 1);

  logic [CFG_W-1:0] half_q;
  logic [CW-1:0]    row_q, col_q;
  logic             busy_q;

  logic [HW-1:0]    h_eff;
  logic [WW-1:0]    win;
  logic [2*WW-1:0]  nsq;
  logic [NW-1:0]    div4n;
  logic [CW-1:0]    side_m1;

  logic             in_acc, cfg_acc, last_in;
  logic [CW-1:0]    r_cur, c_cur;

  // Window geometry from the configured half size, saturated at the maximum.
  always_comb begin
    h_eff   = (32'(half_q) > MAX_HALF_WINDOW) ? HW'(MAX_HALF_WINDOW) : HW'(half_q);
    win     = WW'({h_eff, 1'b1});
    nsq     = (2*WW)'(win) * (2*WW)'(win);
    div4n   = {nsq, 2'b00};
    side_m1 = CW'({h_eff, 1'b0}) + CW'(2);
  end

  assign in_acc      = s_axis_tvalid && s_axis_tready;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = !busy_q;

  // Position of the accepted pixel; the new patch flag restarts at the corner.
  always_comb begin
    r_cur   = s_axis_tuser ? '0 : row_q;
    c_cur   = s_axis_tuser ? '0 : col_q;
    last_in = (r_cur == side_m1) && (c_cur == side_m1);
  end

  // Line buffer: row r-2 and row r-1 at the current column.
  logic [7:0] rd_cur, rd_prev;

  stc_line_mem #(
    .AW (CW + 1),
    .DW (PIXEL_W)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (in_acc),
    .waddr_i   ({r_cur[0], c_cur}),
    .wdata_i   (s_axis_tdata),
    .raddr_a_i ({r_cur[0], c_cur}),
    .raddr_b_i ({~r_cur[0], c_cur}),
    .rdata_a_o (rd_cur),
    .rdata_b_o (rd_prev)
  );

  // Second stage: beat registered while the memory answers.
  logic       v2_q, first2_q, rok2_q, cok2_q, last2_q;
  logic [7:0] pix2_q, p0_q, p1_q;
  logic signed [8:0] dy_q;

  logic [SUM_W-1:0]        sxx_q, syy_q, sxx_d, syy_d;
  logic signed [SUM_W:0]   sxy_q, sxy_d;
  logic signed [8:0]       dx, dy_now;
  logic signed [17:0]      pxx, pyy, pxy;
  logic                    acc_en;

  // Gradients of the centre one column back, and the new sums.
  always_comb begin
    dx     = $signed({1'b0, rd_prev}) - $signed({1'b0, p0_q});
    dy_now = $signed({1'b0, pix2_q}) - $signed({1'b0, rd_cur});
    pxx    = dx * dx;
    pyy    = dy_q * dy_q;
    pxy    = dx * dy_q;
    acc_en = rok2_q && cok2_q;
    sxx_d  = first2_q ? '0 : sxx_q;
    syy_d  = first2_q ? '0 : syy_q;
    sxy_d  = first2_q ? '0 : sxy_q;
    if (acc_en) begin
      sxx_d = sxx_d + SUM_W'(pxx);
      syy_d = syy_d + SUM_W'(pyy);
      sxy_d = sxy_d + (SUM_W+1)'(pxy);
    end
  end

  // Score unit and output register.
  logic                  sc_valid, sc_ready;
  logic [SCORE_W-1:0]    sc_score;
  logic [SCORE_W-1:0]    out_q;
  logic                  out_v_q;

  assign sc_ready = !out_v_q || m_axis_tready;

  stc_score #(
    .SUM_W (SUM_W),
    .NW    (NW)
  ) u_score (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (v2_q && last2_q),
    .sxx_i       (sxx_d),
    .syy_i       (syy_d),
    .sxy_i       (sxy_d),
    .div_i       (div4n),
    .res_valid_o (sc_valid),
    .res_ready_i (sc_ready),
    .score_o     (sc_score)
  );

  // Position counters, configuration register and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= HALF_WINDOW_RESET;
      row_q  <= '0;
      col_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      if (cfg_acc) begin
        half_q <= cfg_data_i;
        row_q  <= '0;
        col_q  <= '0;
      end else if (in_acc) begin
        if (last_in) begin
          row_q <= '0;
          col_q <= '0;
        end else if (c_cur == side_m1) begin
          row_q <= r_cur + 1'b1;
          col_q <= '0;
        end else begin
          row_q <= r_cur;
          col_q <= c_cur + 1'b1;
        end
      end
      if (in_acc && last_in) begin
        busy_q <= 1'b1;
      end else if (sc_valid && sc_ready) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Pipeline stage, column shift of the previous row, and the sums.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q  <= 1'b0;
      sxx_q <= '0;
      syy_q <= '0;
      sxy_q <= '0;
    end else begin
      v2_q <= in_acc;
      if (cfg_acc) begin
        sxx_q <= '0;
        syy_q <= '0;
        sxy_q <= '0;
      end else if (v2_q) begin
        if (last2_q) begin
          sxx_q <= '0;
          syy_q <= '0;
          sxy_q <= '0;
        end else begin
          sxx_q <= sxx_d;
          syy_q <= syy_d;
          sxy_q <= sxy_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix2_q   <= s_axis_tdata;
      first2_q <= s_axis_tuser;
      rok2_q   <= (r_cur >= CW'(2));
      cok2_q   <= (c_cur >= CW'(2));
      last2_q  <= last_in;
    end
    if (v2_q) begin
      dy_q <= dy_now;
      p0_q <= p1_q;
      p1_q <= rd_prev;
    end
  end

  // Output register parts the score unit from the receiver.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (sc_ready) begin
      out_v_q <= sc_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sc_ready && sc_valid) begin
      out_q <= sc_score;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {1'b0, out_q};

endmodule

`default_nettype wire
